[rtl/assert_macros.svh]
// assertion helper macros for the solver checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication whose consequent is checked in the next cycle
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/jls_pkg.sv]
// ----------------------------------------------------------------------------
// jls_pkg
// Types and constants shared by the Jacobi solver modules.
// ----------------------------------------------------------------------------
package jls_pkg;

   localparam int IDX_W = 4;
   localparam int VAL_W = 32;
   localparam int STAT_W = 2;
   localparam int OUT_LIMIT = 16;

   localparam logic [1:0] REG_SIZE = 2'd0;
   localparam logic [1:0] REG_TOL = 2'd1;
   localparam logic [1:0] REG_LIMIT = 2'd2;

   localparam logic OP_COEF = 1'b0;
   localparam logic OP_RHS = 1'b1;

   localparam logic [STAT_W-1:0] ST_CONVERGED = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOT_DOMINANT = 2'd1;
   localparam logic [STAT_W-1:0] ST_LIMIT = 2'd2;

   typedef struct packed {
      logic opcode;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic signed [VAL_W-1:0] value;
      logic last;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic signed [VAL_W-1:0] solution;
      logic [STAT_W-1:0] status;
      logic last_result;
   } rsp_type;

   // command passed from the front end to the solve engine
   typedef struct packed {
      logic wr_coef;
      logic wr_rhs;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic signed [VAL_W-1:0] value;
      logic start;
   } cmd_type;

endpackage

[rtl/jls_stream_if.sv]
// ----------------------------------------------------------------------------
// jls_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface jls_stream_if #(
   parameter int W = 8
);
   logic valid;
   logic ready;
   logic [W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[rtl/jls_front.sv]
// ----------------------------------------------------------------------------
// jls_front
// Accepts load beats, classifies them and queues commands for the engine.
// ----------------------------------------------------------------------------
module jls_front #(
   parameter int MAX_VARS = 16,
   parameter int DEPTH = 4
) (
   input logic clock,
   input logic reset,
   input logic in_valid,
   output logic in_ready,
   input jls_pkg::req_type in_data,
   output logic cmd_valid,
   input logic cmd_ready,
   output jls_pkg::cmd_type cmd_data
);
   localparam int AW = $clog2(DEPTH);

   jls_pkg::cmd_type fifo_ff [DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0] cnt_ff, cnt_in;
   jls_pkg::cmd_type cmd;
   logic push, pop;
   logic row_ok, col_ok;

   always_comb begin
      row_ok = ({28'd0, in_data.row} < 32'(MAX_VARS));
      col_ok = ({28'd0, in_data.col} < 32'(MAX_VARS));
      cmd.wr_coef = (in_data.opcode == jls_pkg::OP_COEF) && row_ok && col_ok;
      cmd.wr_rhs = (in_data.opcode == jls_pkg::OP_RHS) && row_ok;
      cmd.row = in_data.row;
      cmd.col = in_data.col;
      cmd.value = in_data.value;
      cmd.start = in_data.last;
   end

   assign in_ready = (cnt_ff != (AW+1)'(DEPTH));
   assign push = in_valid && in_ready;
   assign cmd_valid = (cnt_ff != '0);
   assign pop = cmd_valid && cmd_ready;
   assign cmd_data = fifo_ff[rp_ff];

   always_comb begin
      wp_in = push ? wp_ff + 1'b1 : wp_ff;
      rp_in = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wp_ff] <= cmd;
      end
   end
endmodule

[rtl/jls_divider.sv]
// ----------------------------------------------------------------------------
// jls_divider
// Restoring divider: (num << FRAC_BITS) / den, truncated, saturated.
// ----------------------------------------------------------------------------
module jls_divider #(
   parameter int FRAC_BITS = 16,
   parameter int NUM_W = 48
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic signed [NUM_W-1:0] num,
   input logic signed [31:0] den,
   output logic done,
   output logic signed [31:0] quot
);
   localparam int DW = NUM_W + FRAC_BITS;
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] n_ff, n_in;
   logic [32:0] r_ff, r_in;
   logic [32:0] d_ff, d_in;
   logic neg_ff, neg_in;
   logic zero_ff, zero_in;
   logic nsign_ff, nsign_in, nzero_ff, nzero_in;
   logic [CW-1:0] c_ff, c_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [33:0] trial;
   logic [NUM_W-1:0] un;
   logic big;
   logic [31:0] mag;

   always_comb begin
      un = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      n_in = n_ff;
      r_in = r_ff;
      d_in = d_ff;
      neg_in = neg_ff;
      zero_in = zero_ff;
      nsign_in = nsign_ff;
      nzero_in = nzero_ff;
      c_in = c_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = '0;
      if (start) begin
         n_in = {un, {FRAC_BITS{1'b0}}};
         r_in = '0;
         d_in = den[31] ? 33'(-{den[31], den}) : {1'b0, den};
         neg_in = num[NUM_W-1] ^ den[31];
         zero_in = (den == '0);
         nsign_in = num[NUM_W-1];
         nzero_in = (num == '0);
         c_in = CW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {r_ff, n_ff[DW-1]} - {1'b0, d_ff};
         if (!trial[33]) begin
            r_in = trial[32:0];
            n_in = {n_ff[DW-2:0], 1'b1};
         end else begin
            r_in = {r_ff[31:0], n_ff[DW-1]};
            n_in = {n_ff[DW-2:0], 1'b0};
         end
         c_in = c_ff - 1'b1;
         if (c_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // quotient bits above 31 (and bit 31 itself) mean overflow, except an exact -2^31 result
   always_comb begin
      big = |n_ff[DW-1:31];
      mag = n_ff[31:0];
      if (zero_ff) begin
         quot = nzero_ff ? 32'sd0 : (nsign_ff ? 32'sh80000000 : 32'sh7fffffff);
      end else if (neg_ff) begin
         quot = (big && !(n_ff[31] && n_ff[30:0] == '0 && !(|n_ff[DW-1:32])))
            ? 32'sh80000000 : 32'(-mag);
      end else begin
         quot = big ? 32'sh7fffffff : 32'(mag);
      end
   end

   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      n_ff <= n_in;
      r_ff <= r_in;
      d_ff <= d_in;
      neg_ff <= neg_in;
      zero_ff <= zero_in;
      nsign_ff <= nsign_in;
      nzero_ff <= nzero_in;
      c_ff <= c_in;
   end
endmodule

[rtl/jls_engine.sv]
// ----------------------------------------------------------------------------
// jls_engine
// Stores the system, checks dominance, runs Jacobi sweeps, emits results.
// ----------------------------------------------------------------------------
module jls_engine #(
   parameter int MAX_VARS = 16,
   parameter int FRAC_BITS = 16
) (
   input logic clock,
   input logic reset,
   input logic cmd_valid,
   output logic cmd_ready,
   input jls_pkg::cmd_type cmd_data,
   input logic [4:0] size_in_use,
   input logic [30:0] tolerance,
   input logic [15:0] iteration_limit,
   output logic out_valid,
   input logic out_ready,
   output jls_pkg::rsp_type out_data
);
   localparam int IW = $clog2(MAX_VARS);
   localparam int NW = 52;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DOM_RD = 4'd1;
   localparam logic [3:0] S_DOM_ACC = 4'd2;
   localparam logic [3:0] S_DOM_CHK = 4'd3;
   localparam logic [3:0] S_SW_RD = 4'd4;
   localparam logic [3:0] S_SW_MUL = 4'd5;
   localparam logic [3:0] S_SW_ACC = 4'd6;
   localparam logic [3:0] S_SW_DIV = 4'd7;
   localparam logic [3:0] S_SW_WAIT = 4'd8;
   localparam logic [3:0] S_SW_UPD = 4'd9;
   localparam logic [3:0] S_EMIT = 4'd10;

   logic signed [31:0] coef_mem [1 << (2*IW)];
   logic signed [31:0] rhs_mem [MAX_VARS];
   logic signed [31:0] cur_ff [MAX_VARS];
   logic signed [31:0] nxt_ff [MAX_VARS];

   logic [3:0] st_ff;
   logic [IW-1:0] i_ff, j_ff;
   logic [IW:0] n_ff;
   logic [15:0] lim_ff, sweep_ff;
   logic signed [31:0] rd_ff, diag_ff, x_ff;
   logic signed [63:0] prod_ff;
   logic signed [NW-1:0] sum_ff;
   logic [37:0] rs_ff, cs_ff;
   logic rows_ok_ff, cols_ok_ff, rdcol_ff, conv_ff;
   logic [1:0] stat_ff;
   logic div_start;
   logic div_done;
   logic signed [31:0] div_q;
   logic ov_ff;
   jls_pkg::rsp_type ob_ff;
   logic [IW*2-1:0] rd_addr;
   logic [IW:0] nreq;
   logic [31:0] amag;
   logic [31:0] dgmag;
   logic signed [32:0] diff;
   logic [32:0] dmag;

   assign cmd_ready = (st_ff == S_IDLE);

   always_comb begin
      if (size_in_use == '0) nreq = (IW+1)'(1);
      else if ({27'd0, size_in_use} > 32'(MAX_VARS)) nreq = (IW+1)'(MAX_VARS);
      else nreq = (IW+1)'(size_in_use);
      if ({27'd0, nreq} > 32'(jls_pkg::OUT_LIMIT)) nreq = (IW+1)'(jls_pkg::OUT_LIMIT);
   end

   // memory read address: row-major, column walk for dominance
   always_comb begin
      if (st_ff == S_DOM_RD && rdcol_ff) rd_addr = {j_ff, i_ff};
      else rd_addr = {i_ff, j_ff};
      amag = rd_ff[31] ? 32'(-rd_ff) : 32'(rd_ff);
      dgmag = diag_ff[31] ? 32'(-diag_ff) : 32'(diag_ff);
      diff = 33'(nxt_ff[i_ff]) - 33'(cur_ff[i_ff]);
      dmag = diff[32] ? 33'(-diff) : 33'(diff);
   end

   always_ff @(posedge clock) begin
      if (cmd_valid && cmd_ready && cmd_data.wr_coef) begin
         coef_mem[{IW'(cmd_data.row), IW'(cmd_data.col)}] <= cmd_data.value;
      end
      if (cmd_valid && cmd_ready && cmd_data.wr_rhs) begin
         rhs_mem[IW'(cmd_data.row)] <= cmd_data.value;
      end
      rd_ff <= coef_mem[rd_addr];
      x_ff <= cur_ff[j_ff];
   end

   assign div_start = (st_ff == S_SW_DIV);

   jls_divider #(.FRAC_BITS(FRAC_BITS), .NUM_W(NW)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(sum_ff), .den(diag_ff), .done(div_done), .quot(div_q)
   );

   assign out_valid = ov_ff;
   assign out_data = ob_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         ov_ff <= 1'b0;
         sweep_ff <= '0;
         for (int k = 0; k < MAX_VARS; k++) cur_ff[k] <= '0;
      end else begin
         case (st_ff)
            S_IDLE: begin
               if (cmd_valid && cmd_data.start) begin
                  n_ff <= nreq;
                  lim_ff <= (iteration_limit == '0) ? 16'd1 : iteration_limit;
                  for (int k = 0; k < MAX_VARS; k++) cur_ff[k] <= '0;
                  sweep_ff <= '0;
                  i_ff <= '0;
                  j_ff <= '0;
                  rdcol_ff <= 1'b0;
                  rs_ff <= '0;
                  cs_ff <= '0;
                  rows_ok_ff <= 1'b1;
                  cols_ok_ff <= 1'b1;
                  st_ff <= S_DOM_RD;
               end
            end
            S_DOM_RD: st_ff <= S_DOM_ACC;
            // two reads per element: row entry then column entry
            S_DOM_ACC: begin
               if (j_ff == i_ff) diag_ff <= rd_ff;
               else if (!rdcol_ff) rs_ff <= rs_ff + 38'(amag);
               else cs_ff <= cs_ff + 38'(amag);
               if (!rdcol_ff) begin
                  rdcol_ff <= 1'b1;
                  st_ff <= S_DOM_RD;
               end else begin
                  rdcol_ff <= 1'b0;
                  if ({1'b0, j_ff} == n_ff - 1'b1) st_ff <= S_DOM_CHK;
                  else begin
                     j_ff <= j_ff + 1'b1;
                     st_ff <= S_DOM_RD;
                  end
               end
            end
            S_DOM_CHK: begin
               if (rs_ff > 38'(dgmag)) rows_ok_ff <= 1'b0;
               if (cs_ff > 38'(dgmag)) cols_ok_ff <= 1'b0;
               rs_ff <= '0;
               cs_ff <= '0;
               j_ff <= '0;
               if ({1'b0, i_ff} == n_ff - 1'b1) begin
                  i_ff <= '0;
                  if (!((rows_ok_ff && !(rs_ff > 38'(dgmag)))
                        || (cols_ok_ff && !(cs_ff > 38'(dgmag))))) begin
                     stat_ff <= jls_pkg::ST_NOT_DOMINANT;
                     for (int k = 0; k < MAX_VARS; k++) nxt_ff[k] <= '0;
                     st_ff <= S_EMIT;
                  end else begin
                     stat_ff <= jls_pkg::ST_LIMIT;
                     conv_ff <= 1'b1;
                     sum_ff <= NW'(rhs_mem[0]);
                     st_ff <= S_SW_RD;
                  end
               end else begin
                  i_ff <= i_ff + 1'b1;
                  st_ff <= S_DOM_RD;
               end
            end
            S_SW_RD: st_ff <= S_SW_MUL;
            S_SW_MUL: begin
               prod_ff <= 64'(rd_ff) * 64'(x_ff);
               if (j_ff == i_ff) diag_ff <= rd_ff;
               st_ff <= S_SW_ACC;
            end
            S_SW_ACC: begin
               if (j_ff != i_ff) sum_ff <= sum_ff - NW'(prod_ff >>> FRAC_BITS);
               if ({1'b0, j_ff} == n_ff - 1'b1) st_ff <= S_SW_DIV;
               else begin
                  j_ff <= j_ff + 1'b1;
                  st_ff <= S_SW_RD;
               end
            end
            S_SW_DIV: st_ff <= S_SW_WAIT;
            S_SW_WAIT: begin
               if (div_done) begin
                  nxt_ff[i_ff] <= div_q;
                  j_ff <= '0;
                  if ({1'b0, i_ff} == n_ff - 1'b1) begin
                     i_ff <= '0;
                     st_ff <= S_SW_UPD;
                  end else begin
                     i_ff <= i_ff + 1'b1;
                     sum_ff <= NW'(rhs_mem[i_ff + 1'b1]);
                     st_ff <= S_SW_RD;
                  end
               end
            end
            S_SW_UPD: begin
               if (!(dmag < {2'b0, tolerance})) conv_ff <= 1'b0;
               cur_ff[i_ff] <= nxt_ff[i_ff];
               if ({1'b0, i_ff} == n_ff - 1'b1) begin
                  i_ff <= '0;
                  sweep_ff <= sweep_ff + 1'b1;
                  if (conv_ff && dmag < {2'b0, tolerance}) begin
                     stat_ff <= jls_pkg::ST_CONVERGED;
                     st_ff <= S_EMIT;
                  end else if (sweep_ff + 1'b1 >= lim_ff) begin
                     st_ff <= S_EMIT;
                  end else begin
                     conv_ff <= 1'b1;
                     sum_ff <= NW'(rhs_mem[0]);
                     st_ff <= S_SW_RD;
                  end
               end else begin
                  i_ff <= i_ff + 1'b1;
               end
            end
            S_EMIT: begin
               if (!ov_ff || out_ready) begin
                  ov_ff <= 1'b1;
                  ob_ff.index <= jls_pkg::IDX_W'(i_ff);
                  ob_ff.solution <= nxt_ff[i_ff];
                  ob_ff.status <= stat_ff;
                  ob_ff.last_result <= ({1'b0, i_ff} == n_ff - 1'b1);
                  if ({1'b0, i_ff} == n_ff - 1'b1) st_ff <= S_IDLE;
                  else i_ff <= i_ff + 1'b1;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
         if (ov_ff && out_ready && !(st_ff == S_EMIT)) ov_ff <= 1'b0;
      end
   end
endmodule

[rtl/jacobi_linear_solver.sv]
// ----------------------------------------------------------------------------
// jacobi_linear_solver
// Fixed-point Gauss-Jacobi solver with load queue and sequential engine.
// ----------------------------------------------------------------------------
// Load beats (one coefficient or right-hand value each) are taken one per
// cycle into a four-entry queue while it has room; the engine, while idle,
// writes them into its stores at one per cycle. A beat with last set starts
// the solve: a dominance check, then the sweeps, whose pace is set by the
// single shared multiplier and the bit-serial divider (68 steps per
// unknown). Results follow at one per cycle while the receiver is ready; the
// engine takes no new loads until the last result has been issued.
module jacobi_linear_solver #(
   parameter int MAX_VARS = 16,
   parameter int FRAC_BITS = 16
) (
   input logic clock,
   input logic reset,
   jls_stream_if.sink req,
   jls_stream_if.source rsp,
   input logic csr_we,
   input logic [1:0] csr_index,
   input logic [30:0] csr_wdata
);
   logic [4:0] size_ff;
   logic [30:0] tol_ff;
   logic [15:0] lim_ff;
   logic cmd_valid, cmd_ready;
   jls_pkg::cmd_type cmd_data;
   jls_pkg::rsp_type rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= 5'd3;
         tol_ff <= 31'd1;
         lim_ff <= 16'd1000;
      end else if (csr_we) begin
         case (csr_index)
            jls_pkg::REG_SIZE: size_ff <= csr_wdata[4:0];
            jls_pkg::REG_TOL: tol_ff <= csr_wdata;
            jls_pkg::REG_LIMIT: lim_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   jls_front #(.MAX_VARS(MAX_VARS), .DEPTH(4)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready),
      .in_data(jls_pkg::req_type'(req.data)),
      .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data)
   );

   jls_engine #(.MAX_VARS(MAX_VARS), .FRAC_BITS(FRAC_BITS)) u_engine (
      .clock(clock), .reset(reset),
      .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data),
      .size_in_use(size_ff), .tolerance(tol_ff), .iteration_limit(lim_ff),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp_data)
   );

   assign rsp.data = rsp_data;
endmodule

[rtl/jls_checker.sv]
// ----------------------------------------------------------------------------
// jls_checker
// Port-level checks on the solver result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jls_rsp_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [38:0] rsp_data
);
   `CHK_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")
   `CHK_IMPLY(a_stat, clock, reset, rsp_valid, rsp_data[2:1] != 2'd3, "bad status code")
   `CHK_NEXT(a_seq, clock, reset, rsp_valid && rsp_ready && !rsp_data[0], !rsp_valid || (rsp_data[38:35] == $past(rsp_data[38:35]) + 4'd1), "result index out of order")
endmodule

bind jacobi_linear_solver jls_rsp_checker u_chk (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
